[hdl/swot_pkg.sv]
// Shared constants for the steered wheel outline transform.
// Holds the CORDIC arctangent table, start gain and register indexes.
// No dependencies.
package swot_pkg;

    localparam int TRIG_W       = 32;
    localparam int TRIG_FRAC    = 30;
    localparam int ATAN_ENTRIES = 24;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MOUNT_X = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOUNT_Y = 1'b1;

    // Q2.30 start vector, pre-scaled by the inverse CORDIC gain.
    localparam logic signed [TRIG_W-1:0] CORDIC_START = 32'sd652032874;
    localparam logic [TRIG_W-1:0]        RND_HALF     = 32'h2000_0000;

    // Arctangent of 2^-i in units of a 32-bit full turn.
    localparam logic signed [TRIG_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'sd536870912, 32'sd316933405, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335086,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860,
        32'sd10430,     32'sd5215,      32'sd2607,      32'sd1303,
        32'sd651,       32'sd325,       32'sd162,       32'sd81
    };

endpackage

[hdl/steered_wheel_outline_transform.sv]
// Steered wheel outline transform: wheel-frame outline point to global point.
// Top level; depends on swot_pkg for the CORDIC table and register indexes.
//
// Usage:
//   s_ channel: one outline point per request, with pose, heading, steer angle
//   and a side flag in s_tuser. m_ channel: one global point per request.
//   cfg_ channel: wheel mount offsets (index 0 forward, 1 lateral), always ready;
//   the user must write it only while the block is idle, unchecked by the block.
// Pipeline: an input stage, one stage per CORDIC iteration, then sign fix,
//   first products, rotation sums, offset sums, heading products, heading sums
//   and the output register with the pose added.
// Throughput: one request per cycle when unstalled; sine and cosine of both
//   angles run in parallel CORDIC pipelines and each multiply has its own stage.
// Reset: aresetn is synchronous and active low; it empties the pipeline and
//   clears both mount offsets to zero.
// Stall: each stage holds while the stage after it is full and stalled, so
//   bubbles close up and s_tready stays high until every stage is occupied.
// All sums after the CORDIC saturate to the signed coordinate range.
module steered_wheel_outline_transform #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16,
    parameter int TRIG_STAGES = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // outline_x, outline_y, pose_x, pose_y, pose_heading, steer_angle, zero pad
    input  logic [((4*COORD_WIDTH+2*ANGLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // side_negative
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // global_x, global_y, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [swot_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);
    import swot_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int AW     = ANGLE_WIDTH;
    localparam int N      = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
    localparam int PW     = CW + TRIG_W;
    localparam int QW     = CW + 3;
    localparam int SW     = CW + 4;
    localparam int MDW    = ((2*CW+7)/8)*8;
    localparam int S_FLIP = N + 1;
    localparam int S_MUL1 = N + 2;
    localparam int S_RXY  = N + 3;
    localparam int S_XYT  = N + 4;
    localparam int S_MUL2 = N + 5;
    localparam int S_LXY  = N + 6;
    localparam int L      = N + 8;

    typedef struct packed {
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic                 neg;
    } base_t;

    function automatic logic [TRIG_W:0] angle_prep(input logic [AW-1:0] ang);
        logic [TRIG_W-1:0] a;
        logic              flip;
        a    = {ang, {(TRIG_W-AW){1'b0}}};
        flip = a[TRIG_W-1] ^ a[TRIG_W-2];
        return {flip, a[TRIG_W-1] ^ flip, a[TRIG_W-2:0]};
    endfunction

    function automatic logic signed [QW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        t = $signed({p[PW-1], p}) + $signed({{(PW+1-TRIG_W){1'b0}}, RND_HALF});
        return t[PW:TRIG_FRAC];
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        if (&v[SW-1:CW-1] || ~|v[SW-1:CW-1]) begin
            return v[CW-1:0];
        end else begin
            return v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    logic [L-1:0]           v_reg;
    logic [L:0]             stage_en;
    base_t                  base_reg [L];
    logic signed [CW-1:0]   off_x_reg, off_y_reg;

    logic signed [TRIG_W-1:0] sx_reg [N+1];
    logic signed [TRIG_W-1:0] sy_reg [N+1];
    logic signed [TRIG_W-1:0] sz_reg [N+1];
    logic signed [TRIG_W-1:0] hx_reg [N+1];
    logic signed [TRIG_W-1:0] hy_reg [N+1];
    logic signed [TRIG_W-1:0] hz_reg [N+1];
    logic [N:0]               sf_reg, hf_reg;

    logic signed [TRIG_W-1:0] sc_reg, ss_reg;
    logic signed [TRIG_W-1:0] hc_reg [4];
    logic signed [TRIG_W-1:0] hs_reg [4];
    logic signed [PW-1:0]     p_oxc_reg, p_oys_reg, p_oyc_reg, p_oxs_reg;
    logic signed [CW-1:0]     rx_reg, ry_reg, myn_reg, xt_reg, yt_reg;
    logic signed [PW-1:0]     p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [CW-1:0]     lx_reg, ly_reg, gx_reg, gy_reg;

    logic [TRIG_W:0] steer_prep, head_prep;
    base_t           in_base;
    logic signed [QW-1:0] q_oxc, q_oys, q_oyc, q_oxs;

    assign in_base.ox  = s_tdata[CW-1:0];
    assign in_base.oy  = s_tdata[2*CW-1:CW];
    assign in_base.px  = s_tdata[3*CW-1:2*CW];
    assign in_base.py  = s_tdata[4*CW-1:3*CW];
    assign in_base.neg = s_tuser[0];
    assign head_prep   = angle_prep(s_tdata[4*CW+AW-1:4*CW]);
    assign steer_prep  = angle_prep(s_tdata[4*CW+2*AW-1:4*CW+AW]);

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        stage_en[L] = m_tready;
        for (int i = L - 1; i >= 0; i--) begin
            stage_en[i] = !v_reg[i] || stage_en[i+1];
        end
    end

    assign s_tready  = stage_en[0];
    assign m_tvalid  = v_reg[L-1];
    assign m_tdata   = MDW'({gy_reg, gx_reg});
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            off_x_reg <= '0;
            off_y_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < L; i++) begin
                if (stage_en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MOUNT_X: off_x_reg <= cfg_data;
                    CFG_MOUNT_Y: off_y_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Base payload and the CORDIC pipelines.
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            base_reg[0] <= in_base;
            sf_reg[0]   <= steer_prep[TRIG_W];
            sz_reg[0]   <= steer_prep[TRIG_W-1:0];
            sx_reg[0]   <= CORDIC_START;
            sy_reg[0]   <= '0;
            hf_reg[0]   <= head_prep[TRIG_W];
            hz_reg[0]   <= head_prep[TRIG_W-1:0];
            hx_reg[0]   <= CORDIC_START;
            hy_reg[0]   <= '0;
        end
        for (int i = 1; i < L; i++) begin
            if (stage_en[i]) begin
                base_reg[i] <= base_reg[i-1];
            end
        end
        for (int k = 0; k < N; k++) begin
            if (stage_en[k+1]) begin
                sf_reg[k+1] <= sf_reg[k];
                hf_reg[k+1] <= hf_reg[k];
                if (!sz_reg[k][TRIG_W-1]) begin
                    sx_reg[k+1] <= sx_reg[k] - (sy_reg[k] >>> k);
                    sy_reg[k+1] <= sy_reg[k] + (sx_reg[k] >>> k);
                    sz_reg[k+1] <= sz_reg[k] - ATAN_TURNS[k];
                end else begin
                    sx_reg[k+1] <= sx_reg[k] + (sy_reg[k] >>> k);
                    sy_reg[k+1] <= sy_reg[k] - (sx_reg[k] >>> k);
                    sz_reg[k+1] <= sz_reg[k] + ATAN_TURNS[k];
                end
                if (!hz_reg[k][TRIG_W-1]) begin
                    hx_reg[k+1] <= hx_reg[k] - (hy_reg[k] >>> k);
                    hy_reg[k+1] <= hy_reg[k] + (hx_reg[k] >>> k);
                    hz_reg[k+1] <= hz_reg[k] - ATAN_TURNS[k];
                end else begin
                    hx_reg[k+1] <= hx_reg[k] + (hy_reg[k] >>> k);
                    hy_reg[k+1] <= hy_reg[k] - (hx_reg[k] >>> k);
                    hz_reg[k+1] <= hz_reg[k] + ATAN_TURNS[k];
                end
            end
        end
    end

    assign q_oxc = rnd(p_oxc_reg);
    assign q_oys = rnd(p_oys_reg);
    assign q_oyc = rnd(p_oyc_reg);
    assign q_oxs = rnd(p_oxs_reg);

    // Arithmetic after the CORDIC: sign fix, steer turn, offsets, heading, pose.
    always_ff @(posedge aclk) begin
        if (stage_en[S_FLIP]) begin
            sc_reg    <= sf_reg[N] ? -sx_reg[N] : sx_reg[N];
            ss_reg    <= sf_reg[N] ? -sy_reg[N] : sy_reg[N];
            hc_reg[0] <= hf_reg[N] ? -hx_reg[N] : hx_reg[N];
            hs_reg[0] <= hf_reg[N] ? -hy_reg[N] : hy_reg[N];
        end
        for (int j = 1; j < 4; j++) begin
            if (stage_en[S_FLIP+j]) begin
                hc_reg[j] <= hc_reg[j-1];
                hs_reg[j] <= hs_reg[j-1];
            end
        end
        if (stage_en[S_MUL1]) begin
            p_oxc_reg <= base_reg[S_FLIP].ox * sc_reg;
            p_oys_reg <= base_reg[S_FLIP].oy * ss_reg;
            p_oyc_reg <= base_reg[S_FLIP].oy * sc_reg;
            p_oxs_reg <= base_reg[S_FLIP].ox * ss_reg;
        end
        if (stage_en[S_RXY]) begin
            if (base_reg[S_MUL1].neg) begin
                rx_reg  <= sat(SW'(q_oxc) - SW'(q_oys));
                ry_reg  <= sat(-SW'(q_oyc) - SW'(q_oxs));
                myn_reg <= sat(-SW'(off_y_reg));
            end else begin
                rx_reg  <= sat(SW'(q_oxc) + SW'(q_oys));
                ry_reg  <= sat(SW'(q_oyc) - SW'(q_oxs));
                myn_reg <= off_y_reg;
            end
        end
        if (stage_en[S_XYT]) begin
            xt_reg <= sat(SW'(off_x_reg) + SW'(rx_reg));
            yt_reg <= sat(SW'(myn_reg) + SW'(ry_reg));
        end
        if (stage_en[S_MUL2]) begin
            p_xc_reg <= xt_reg * hc_reg[3];
            p_ys_reg <= yt_reg * hs_reg[3];
            p_xs_reg <= xt_reg * hs_reg[3];
            p_yc_reg <= yt_reg * hc_reg[3];
        end
        if (stage_en[S_LXY]) begin
            lx_reg <= sat(SW'(rnd(p_xc_reg)) + SW'(rnd(p_ys_reg)));
            ly_reg <= sat(SW'(rnd(p_xs_reg)) - SW'(rnd(p_yc_reg)));
        end
        if (stage_en[L-1]) begin
            gx_reg <= sat(SW'(lx_reg) + SW'(base_reg[S_LXY].px));
            gy_reg <= sat(SW'(ly_reg) + SW'(base_reg[S_LXY].py));
        end
    end

    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid directly after reset");

    a_full_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while the whole pipeline is stalled");

    a_last_stage_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_en[L-1] && v_reg[L-2]) |=> m_tvalid)
        else $error("item lost on its way into the output stage");

    a_first_stage_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted request did not enter the pipeline");

endmodule

[bench/steered_wheel_outline_transform_test.sv]
// Testbench for the steered wheel outline transform: random and directed points
// checked against a bit-exact predictor of the CORDIC, products and saturating sums.
// Depends on swot_pkg and the steered_wheel_outline_transform top level.
`timescale 1ns / 1ps

module steered_wheel_outline_transform_test;
    import swot_pkg::*;

    localparam int CW = 32;
    localparam int AW = 16;
    localparam int STAGES = 16;
    localparam int IN_W = ((4*CW+2*AW+7)/8)*8;
    localparam int OUT_W = ((2*CW+7)/8)*8;
    localparam int LATENCY = 24;

    typedef struct packed {
        logic              side_neg;
        logic [AW-1:0]     steer;
        logic [AW-1:0]     heading;
        logic [CW-1:0]     py;
        logic [CW-1:0]     px;
        logic [CW-1:0]     oy;
        logic [CW-1:0]     ox;
    } point_t;

    typedef struct packed {
        logic [CW-1:0] gy;
        logic [CW-1:0] gx;
    } global_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_MOUNT_X;
    logic [CW-1:0] cfg_data = '0;

    steered_wheel_outline_transform u_top (.*);

    point_t  pending_points[$];
    global_t expected_globals[$];
    longint  mount_x = 0, mount_y = 0;
    int      mismatches = 0;
    bit      quiet = 0;
    int      send_gap = 0, take_gap = 0;

    initial forever #5 aclk = ~aclk;

    function automatic longint sat_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Exact floor((a*t + 2^29) / 2^30); a and t fit 32 bits so 64 bits suffice.
    function automatic longint trig_mul(longint a, longint t);
        return (a * t + 64'sd536870912) >>> 30;
    endfunction

    function automatic void cordic(logic [AW-1:0] ang, output longint c, output longint s);
        logic [31:0] a;
        longint x, y, z, dx, dy;
        bit flip;
        a = {ang, {(32-AW){1'b0}}};
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) a[31] = ~a[31];
        x = 652032874; y = 0; z = longint'($signed(a));
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
            end
        end
        if (flip) begin x = -x; y = -y; end
        c = x; s = y;
    endfunction

    function automatic global_t place_point(point_t p);
        longint ox, oy, sc, ss, hc, hs, t1, t2, my, rx, ry, xt, yt, lx, ly;
        global_t g;
        ox = longint'($signed(p.ox)); oy = longint'($signed(p.oy));
        my = mount_y;
        cordic(p.steer, sc, ss);
        cordic(p.heading, hc, hs);
        t1 = trig_mul(oy, ss);
        t2 = trig_mul(oy, sc);
        if (p.side_neg) begin t1 = -t1; t2 = -t2; my = sat_coord(-my); end
        rx = sat_coord(trig_mul(ox, sc) + t1);
        ry = sat_coord(t2 - trig_mul(ox, ss));
        xt = sat_coord(mount_x + rx);
        yt = sat_coord(my + ry);
        lx = sat_coord(trig_mul(xt, hc) + trig_mul(yt, hs));
        ly = sat_coord(trig_mul(xt, hs) - trig_mul(yt, hc));
        g.gx = CW'(sat_coord(lx + longint'($signed(p.px))));
        g.gy = CW'(sat_coord(ly + longint'($signed(p.py))));
        return g;
    endfunction

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Request driver: the prediction is made at acceptance with the current offsets.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_globals.insert(expected_globals.size(),
                place_point(point_t'({s_tuser, s_tdata[4*CW+2*AW-1:0]})));
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 0;
                end else if (pending_points.size() > 0) begin
                    point_t p;
                    p = pending_points.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= IN_W'(p[4*CW+2*AW-1:0]);
                    s_tuser <= p.side_neg;
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 13);
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                global_t got, want;
                got = m_tdata[2*CW-1:0];
                if (expected_globals.size() == 0) begin
                    $display("unexpected global point %h at %0t", got, $realtime);
                    mismatches++;
                end else begin
                    want = expected_globals.pop_front();
                    if (got.gx !== want.gx) report_mismatch("global_x", got.gx, want.gx);
                    if (got.gy !== want.gy) report_mismatch("global_y", got.gy, want.gy);
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if (!quiet && $urandom_range(0, 9) == 0) take_gap = $urandom_range(1, 13);
            end
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return CW'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.ox = rand_coord(); p.oy = rand_coord();
        p.px = rand_coord(); p.py = rand_coord();
        p.heading = AW'($urandom); p.steer = AW'($urandom); p.side_neg = 1'($urandom);
        return p;
    endfunction

    task automatic write_mount(logic [CFG_INDEX_W-1:0] idx, logic [CW-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == CFG_MOUNT_X) mount_x = longint'($signed(val));
        else mount_y = longint'($signed(val));
    endtask

    task automatic drain();
        wait (pending_points.size() == 0 && !s_tvalid && expected_globals.size() == 0);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    initial begin
        logic [CW-1:0] mounts [4] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000};
        logic [AW-1:0] angles [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                                      16'h7fff, 16'h3fff, 16'h4001, 16'hffff};
        point_t p;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        // Directed: extreme coordinates at quadrant boundaries, both sides.
        for (int i = 0; i < 24; i++) begin
            p.ox = (i % 3 == 0) ? 32'h7fff_ffff : (i % 3 == 1) ? 32'h8000_0000 : 32'h0001_0000;
            p.oy = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
            p.px = (i % 4 < 2) ? 32'h7fff_ffff : 32'h8000_0000;
            p.py = (i % 5 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            p.heading = angles[i % 8];
            p.steer = angles[(i * 3) % 8];
            p.side_neg = i[0] ^ i[3];
            pending_points.insert(pending_points.size(), p);
        end
        drain();
        // Random phases across mount offset settings, extremes included.
        for (int ph = 0; ph < 5; ph++) begin
            write_mount(CFG_MOUNT_X, ph < 4 ? mounts[ph] : CW'($urandom));
            write_mount(CFG_MOUNT_Y, ph < 4 ? mounts[3 - ph] : CW'($urandom));
            if (ph == 4) quiet = 1;
            for (int i = 0; i < 250; i++)
                pending_points.insert(pending_points.size(), rand_point());
            drain();
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
